/* rtl/i2cee_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared types and codes for the I2C EEPROM transfer sequencer.
// No dependencies; the core takes everything here by scoped names.

package i2cee_pkg;

  // Input item kinds, carried on in_tuser.
  localparam logic [2:0] MODE_BEGIN_WR = 3'd0;
  localparam logic [2:0] MODE_BEGIN_RD = 3'd1;
  localparam logic [2:0] MODE_DATA     = 3'd2;
  localparam logic [2:0] MODE_STATUS   = 3'd3;
  localparam logic [2:0] MODE_WAIT_END = 3'd4;

  // Commands issued to the byte engine and to the host.
  typedef enum logic [3:0] {
    CMD_START     = 4'd0,
    CMD_SEND      = 4'd1,
    CMD_READ_ACK  = 4'd2,
    CMD_READ_NACK = 4'd3,
    CMD_STOP      = 4'd4,
    CMD_WAIT      = 4'd5,
    CMD_NEED      = 4'd6,
    CMD_DATA      = 4'd7,
    CMD_DONE      = 4'd8,
    CMD_ERROR     = 4'd9
  } cmd_t;

  // Error classes reported with an error command.
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_STATUS   = 2'd1,
    ERR_SEQUENCE = 2'd2
  } err_t;

  // Status codes the byte engine reports after each bus operation.
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RESTART    = 8'h10;
  localparam logic [7:0] ST_DEVW_ACK   = 8'h18;
  localparam logic [7:0] ST_TX_ACK     = 8'h28;
  localparam logic [7:0] ST_DEVR_ACK   = 8'h40;
  localparam logic [7:0] ST_RX_ACK     = 8'h50;
  localparam logic [7:0] ST_RX_NACK    = 8'h58;

  // Transfer phases, one-hot.
  typedef enum logic [11:0] {
    PH_IDLE    = 12'b0000_0000_0001,
    PH_START   = 12'b0000_0000_0010,
    PH_DEVW    = 12'b0000_0000_0100,
    PH_ADDRH   = 12'b0000_0000_1000,
    PH_ADDRL   = 12'b0000_0001_0000,
    PH_NEED    = 12'b0000_0010_0000,
    PH_DATA    = 12'b0000_0100_0000,
    PH_WAIT    = 12'b0000_1000_0000,
    PH_RESTART = 12'b0001_0000_0000,
    PH_DEVR    = 12'b0010_0000_0000,
    PH_RDACK   = 12'b0100_0000_0000,
    PH_RDNACK  = 12'b1000_0000_0000
  } phase_t;

  // One result beat as held in the result queue.
  typedef struct packed {
    logic       last;
    cmd_t       command;
    logic [7:0] byte_value;
    err_t       error_kind;
    logic [7:0] bad_status;
  } res_t;

endpackage

`default_nettype wire

/* rtl/i2c_eeprom_transfer_sequencer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// I2C EEPROM transfer sequencer: phase logic and result queue.
// Depends on i2cee_pkg for command, phase and result types.

// The sequencer turns begin-write and begin-read requests into byte-level
// bus commands for an external byte engine, splits writes at PAGE_SIZE
// boundaries and checks every status the engine reports against the code
// expected for the current phase; a mismatch or an item that does not fit
// the phase aborts with an error beat and no stop. Each input beat is
// handled in the cycle it is accepted and its one to three results are
// pushed into a four-entry result queue, so an input beat can be taken in
// every cycle while the queue has room for three results, which is when
// in_tready is high. Results leave at one per cycle while out_tready is
// high; the results of one beat go out one after another. No clearing
// pass is needed after reset.

module i2c_eeprom_transfer_sequencer_core #(
  parameter int unsigned PAGE_SIZE = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  // Input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  // in_tdata: start_address[15:0], byte_count[31:16], data_byte[39:32],
  //           bus_status[47:40]
  input  wire  [47:0] in_tdata,
  // in_tuser: mode[2:0]
  input  wire  [2:0]  in_tuser,
  // Result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  // out_tdata: byte_value[7:0], error_kind[9:8], bad_status[17:10], zero[23:18]
  output logic [23:0] out_tdata,
  // out_tuser: command[3:0]
  output logic [3:0]  out_tuser,
  output logic        out_tlast,
  // Configuration: device_address
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_data
);

  localparam int unsigned QDEPTH = 4;
  localparam logic [8:0]  PAGE9  = 9'(PAGE_SIZE);

  typedef logic [255:0][7:0] mod_tbl_t;

  // Remainder tables for the low and high address bytes.
  function automatic mod_tbl_t build_lo_tbl();
    mod_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 8'(i % PAGE_SIZE);
    end
    return t;
  endfunction

  function automatic mod_tbl_t build_hi_tbl();
    mod_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 8'((i * 256) % PAGE_SIZE);
    end
    return t;
  endfunction

  localparam mod_tbl_t LO_MOD = build_lo_tbl();
  localparam mod_tbl_t HI_MOD = build_hi_tbl();

  function automatic i2cee_pkg::res_t mk_res(i2cee_pkg::cmd_t c, logic [7:0] b,
                                             i2cee_pkg::err_t k, logic [7:0] s);
    i2cee_pkg::res_t r;
    r.last       = 1'b0;
    r.command    = c;
    r.byte_value = b;
    r.error_kind = k;
    r.bad_status = s;
    return r;
  endfunction

  // State
  i2cee_pkg::phase_t phase_r, phase_nxt;
  logic              is_read_r, is_read_nxt;
  logic [15:0]       cur_addr_r, cur_addr_nxt;
  logic [15:0]       remain_r, remain_nxt;
  logic [8:0]        page_left_r, page_left_nxt;
  logic [7:0]        dev_addr_r;

  // Result queue
  i2cee_pkg::res_t   q_mem [QDEPTH];
  logic [1:0]        q_wr_ptr_r;
  logic [1:0]        q_rd_ptr_r;
  logic [2:0]        q_count_r;

  // Input beat fields
  logic [2:0]        in_mode;
  logic [15:0]       in_start_address;
  logic [15:0]       in_byte_count;
  logic [7:0]        in_data_byte;
  logic [7:0]        in_bus_status;

  assign in_mode          = in_tuser;
  assign in_start_address = in_tdata[15:0];
  assign in_byte_count    = in_tdata[31:16];
  assign in_data_byte     = in_tdata[39:32];
  assign in_bus_status    = in_tdata[47:40];

  logic in_acc, out_acc;
  assign in_tready = (q_count_r <= 3'(QDEPTH - 3));
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;

  // Page chunk: bytes from the address up to the next page boundary,
  // limited by the bytes still to go.
  logic        pg_begin;
  logic [15:0] pg_addr;
  logic [15:0] pg_remain;
  logic [8:0]  pg_sum;
  logic [8:0]  pg_off;
  logic [8:0]  pg_room;
  logic [8:0]  pg_chunk;

  always_comb begin
    pg_begin  = (in_mode == i2cee_pkg::MODE_BEGIN_WR);
    pg_addr   = pg_begin ? in_start_address : cur_addr_r;
    pg_remain = pg_begin ? in_byte_count : remain_r;
    pg_sum    = {1'b0, LO_MOD[pg_addr[7:0]]} + {1'b0, HI_MOD[pg_addr[15:8]]};
    pg_off    = (pg_sum >= PAGE9) ? (pg_sum - PAGE9) : pg_sum;
    pg_room   = PAGE9 - pg_off;
    pg_chunk  = ({7'd0, pg_room} > pg_remain) ? pg_remain[8:0] : pg_room;
  end

  // Expected status for the current phase; want_ok is low where no status
  // report is expected.
  logic       want_ok;
  logic [7:0] want_st;

  always_comb begin
    want_ok = 1'b1;
    want_st = 8'd0;
    case (phase_r)
      i2cee_pkg::PH_START:   want_st = i2cee_pkg::ST_START;
      i2cee_pkg::PH_RESTART: want_st = i2cee_pkg::ST_RESTART;
      i2cee_pkg::PH_DEVW:    want_st = i2cee_pkg::ST_DEVW_ACK;
      i2cee_pkg::PH_ADDRH,
      i2cee_pkg::PH_ADDRL,
      i2cee_pkg::PH_DATA:    want_st = i2cee_pkg::ST_TX_ACK;
      i2cee_pkg::PH_DEVR:    want_st = i2cee_pkg::ST_DEVR_ACK;
      i2cee_pkg::PH_RDACK:   want_st = i2cee_pkg::ST_RX_ACK;
      i2cee_pkg::PH_RDNACK:  want_st = i2cee_pkg::ST_RX_NACK;
      default:               want_ok = 1'b0;
    endcase
  end

  // Phase logic: next state and the results of the accepted beat.
  i2cee_pkg::res_t res [3];
  logic [1:0]      n_res;
  i2cee_pkg::res_t unexp_res;
  i2cee_pkg::cmd_t rd_cmd;
  i2cee_pkg::phase_t rd_phase;

  always_comb begin
    phase_nxt     = phase_r;
    is_read_nxt   = is_read_r;
    cur_addr_nxt  = cur_addr_r;
    remain_nxt    = remain_r;
    page_left_nxt = page_left_r;
    n_res         = 2'd0;
    for (int k = 0; k < 3; k++) begin
      res[k] = '0;
    end
    unexp_res = mk_res(i2cee_pkg::CMD_ERROR, 8'd0, i2cee_pkg::ERR_SEQUENCE, 8'd0);

    // Next read command, from the count as it stands after this beat.
    if (((phase_r == i2cee_pkg::PH_RDACK) ? (remain_r - 16'd1) : remain_r) == 16'd1) begin
      rd_cmd   = i2cee_pkg::CMD_READ_NACK;
      rd_phase = i2cee_pkg::PH_RDNACK;
    end else begin
      rd_cmd   = i2cee_pkg::CMD_READ_ACK;
      rd_phase = i2cee_pkg::PH_RDACK;
    end

    if (in_acc) begin
      case (in_mode)
        i2cee_pkg::MODE_BEGIN_WR,
        i2cee_pkg::MODE_BEGIN_RD: begin
          n_res = 2'd1;
          if (phase_r != i2cee_pkg::PH_IDLE) begin
            res[0]    = unexp_res;
            phase_nxt = i2cee_pkg::PH_IDLE;
          end else if (in_byte_count == 16'd0) begin
            res[0] = mk_res(i2cee_pkg::CMD_DONE, 8'd0, i2cee_pkg::ERR_NONE, 8'd0);
          end else begin
            is_read_nxt   = (in_mode == i2cee_pkg::MODE_BEGIN_RD);
            cur_addr_nxt  = in_start_address;
            remain_nxt    = in_byte_count;
            page_left_nxt = (in_mode == i2cee_pkg::MODE_BEGIN_RD) ? 9'd0 : pg_chunk;
            res[0]    = mk_res(i2cee_pkg::CMD_START, 8'd0, i2cee_pkg::ERR_NONE, 8'd0);
            phase_nxt = i2cee_pkg::PH_START;
          end
        end
        i2cee_pkg::MODE_DATA: begin
          n_res = 2'd1;
          if (phase_r != i2cee_pkg::PH_NEED) begin
            res[0]    = unexp_res;
            phase_nxt = i2cee_pkg::PH_IDLE;
          end else begin
            res[0] = mk_res(i2cee_pkg::CMD_SEND, in_data_byte, i2cee_pkg::ERR_NONE, 8'd0);
            cur_addr_nxt  = cur_addr_r + 16'd1;
            remain_nxt    = remain_r - 16'd1;
            page_left_nxt = page_left_r - 9'd1;
            phase_nxt     = i2cee_pkg::PH_DATA;
          end
        end
        i2cee_pkg::MODE_STATUS: begin
          n_res = 2'd1;
          if (!want_ok) begin
            res[0]    = unexp_res;
            phase_nxt = i2cee_pkg::PH_IDLE;
          end else if (in_bus_status != want_st) begin
            res[0] = mk_res(i2cee_pkg::CMD_ERROR, 8'd0, i2cee_pkg::ERR_STATUS,
                            in_bus_status);
            phase_nxt = i2cee_pkg::PH_IDLE;
          end else begin
            case (phase_r)
              i2cee_pkg::PH_START: begin
                res[0] = mk_res(i2cee_pkg::CMD_SEND, {dev_addr_r[7:1], 1'b0},
                                i2cee_pkg::ERR_NONE, 8'd0);
                phase_nxt = i2cee_pkg::PH_DEVW;
              end
              i2cee_pkg::PH_DEVW: begin
                res[0] = mk_res(i2cee_pkg::CMD_SEND, cur_addr_r[15:8],
                                i2cee_pkg::ERR_NONE, 8'd0);
                phase_nxt = i2cee_pkg::PH_ADDRH;
              end
              i2cee_pkg::PH_ADDRH: begin
                res[0] = mk_res(i2cee_pkg::CMD_SEND, cur_addr_r[7:0],
                                i2cee_pkg::ERR_NONE, 8'd0);
                phase_nxt = i2cee_pkg::PH_ADDRL;
              end
              i2cee_pkg::PH_ADDRL: begin
                if (is_read_r) begin
                  res[0] = mk_res(i2cee_pkg::CMD_START, 8'd0, i2cee_pkg::ERR_NONE, 8'd0);
                  phase_nxt = i2cee_pkg::PH_RESTART;
                end else begin
                  res[0] = mk_res(i2cee_pkg::CMD_NEED, 8'd0, i2cee_pkg::ERR_NONE, 8'd0);
                  phase_nxt = i2cee_pkg::PH_NEED;
                end
              end
              i2cee_pkg::PH_DATA: begin
                if (page_left_r != 9'd0) begin
                  res[0] = mk_res(i2cee_pkg::CMD_NEED, 8'd0, i2cee_pkg::ERR_NONE, 8'd0);
                  phase_nxt = i2cee_pkg::PH_NEED;
                end else begin
                  // Page complete: stop, then let the EEPROM program it.
                  n_res  = 2'd2;
                  res[0] = mk_res(i2cee_pkg::CMD_STOP, 8'd0, i2cee_pkg::ERR_NONE, 8'd0);
                  res[1] = mk_res(i2cee_pkg::CMD_WAIT, 8'd0, i2cee_pkg::ERR_NONE, 8'd0);
                  phase_nxt = i2cee_pkg::PH_WAIT;
                end
              end
              i2cee_pkg::PH_RESTART: begin
                res[0] = mk_res(i2cee_pkg::CMD_SEND, {dev_addr_r[7:1], 1'b1},
                                i2cee_pkg::ERR_NONE, 8'd0);
                phase_nxt = i2cee_pkg::PH_DEVR;
              end
              i2cee_pkg::PH_DEVR: begin
                res[0]    = mk_res(rd_cmd, 8'd0, i2cee_pkg::ERR_NONE, 8'd0);
                phase_nxt = rd_phase;
              end
              i2cee_pkg::PH_RDACK: begin
                n_res  = 2'd2;
                res[0] = mk_res(i2cee_pkg::CMD_DATA, in_data_byte, i2cee_pkg::ERR_NONE, 8'd0);
                res[1] = mk_res(rd_cmd, 8'd0, i2cee_pkg::ERR_NONE, 8'd0);
                cur_addr_nxt = cur_addr_r + 16'd1;
                remain_nxt   = remain_r - 16'd1;
                phase_nxt    = rd_phase;
              end
              default: begin
                // Last byte read with NACK: deliver it, stop and finish.
                n_res  = 2'd3;
                res[0] = mk_res(i2cee_pkg::CMD_DATA, in_data_byte, i2cee_pkg::ERR_NONE, 8'd0);
                res[1] = mk_res(i2cee_pkg::CMD_STOP, 8'd0, i2cee_pkg::ERR_NONE, 8'd0);
                res[2] = mk_res(i2cee_pkg::CMD_DONE, 8'd0, i2cee_pkg::ERR_NONE, 8'd0);
                cur_addr_nxt = cur_addr_r + 16'd1;
                remain_nxt   = 16'd0;
                phase_nxt    = i2cee_pkg::PH_IDLE;
              end
            endcase
          end
        end
        i2cee_pkg::MODE_WAIT_END: begin
          n_res = 2'd1;
          if (phase_r != i2cee_pkg::PH_WAIT) begin
            res[0]    = unexp_res;
            phase_nxt = i2cee_pkg::PH_IDLE;
          end else if (remain_r != 16'd0) begin
            page_left_nxt = pg_chunk;
            res[0]    = mk_res(i2cee_pkg::CMD_START, 8'd0, i2cee_pkg::ERR_NONE, 8'd0);
            phase_nxt = i2cee_pkg::PH_START;
          end else begin
            res[0]    = mk_res(i2cee_pkg::CMD_DONE, 8'd0, i2cee_pkg::ERR_NONE, 8'd0);
            phase_nxt = i2cee_pkg::PH_IDLE;
          end
        end
        default: begin
          n_res     = 2'd1;
          res[0]    = unexp_res;
          phase_nxt = i2cee_pkg::PH_IDLE;
        end
      endcase

      // Mark the final result of this beat.
      case (n_res)
        2'd1:    res[0].last = 1'b1;
        2'd2:    res[1].last = 1'b1;
        2'd3:    res[2].last = 1'b1;
        default: res[0].last = res[0].last;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= i2cee_pkg::PH_IDLE;
      is_read_r   <= 1'b0;
      cur_addr_r  <= 16'd0;
      remain_r    <= 16'd0;
      page_left_r <= 9'd0;
      dev_addr_r  <= 8'd160;
    end else begin
      phase_r     <= phase_nxt;
      is_read_r   <= is_read_nxt;
      cur_addr_r  <= cur_addr_nxt;
      remain_r    <= remain_nxt;
      page_left_r <= page_left_nxt;
      if (cfg_valid && cfg_ready) begin
        dev_addr_r <= cfg_data;
      end
    end
  end

  // Result queue storage: up to three entries written per beat.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < n_res) begin
        q_mem[q_wr_ptr_r + 2'(k)] <= res[k];
      end
    end
  end

  // Result queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_ptr_r <= 2'd0;
      q_rd_ptr_r <= 2'd0;
      q_count_r  <= 3'd0;
    end else begin
      q_wr_ptr_r <= q_wr_ptr_r + n_res;
      q_rd_ptr_r <= q_rd_ptr_r + {1'b0, out_acc};
      q_count_r  <= q_count_r + {1'b0, n_res} - {2'b00, out_acc};
    end
  end

  // Output beat from the head of the queue.
  i2cee_pkg::res_t head;
  assign head       = q_mem[q_rd_ptr_r];
  assign out_tvalid = (q_count_r != 3'd0);
  assign out_tuser  = head.command;
  assign out_tdata  = {6'd0, head.bad_status, head.error_kind, head.byte_value};
  assign out_tlast  = head.last;

  // Assertions
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count_r <= 3'(QDEPTH))
    else $error("result queue fill level beyond its depth");

  a_beat_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> n_res != 2'd0)
    else $error("accepted input beat produced no result");

  a_need_is_write: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == i2cee_pkg::PH_NEED |-> (page_left_r != 9'd0) && !is_read_r)
    else $error("data requested outside a write page with bytes left");

  a_begin_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == i2cee_pkg::PH_IDLE && in_byte_count != 16'd0 &&
     (in_mode == i2cee_pkg::MODE_BEGIN_WR || in_mode == i2cee_pkg::MODE_BEGIN_RD))
    |=> phase_r == i2cee_pkg::PH_START)
    else $error("begin request did not enter the start phase");

endmodule

`default_nettype wire
